// ----- hdl/mrte_pkg.sv -----
// Shared types, codes and constants of the mailbox ring transaction engine.
package mrte_pkg;

	// Ring size bound; the effective ring length is clamped to this and to 64
	localparam int MaxRingSlots = 64;
	localparam int RingCap      = (MaxRingSlots < 64) ? MaxRingSlots : 64;
	localparam logic [6:0] RING_CAP = 7'(RingCap);
	localparam logic [6:0] RING_MIN = 7'd2;

	// Input word kinds
	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_REAR    = 2'd1,
		OP_REPLY   = 2'd2,
		OP_TICK    = 2'd3
	} opcode_t;

	// Request kinds
	localparam logic [1:0] REQ_READ   = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;

	// Result word kinds
	typedef enum logic [1:0] {
		EV_POSTED   = 2'd0,
		EV_DONE     = 2'd1,
		EV_FAILED   = 2'd2,
		EV_REJECTED = 2'd3
	} event_t;

	// Failure causes
	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_FULL     = 2'd1;
	localparam logic [1:0] CAUSE_NO_REPLY = 2'd2;

	// Transaction state, one-hot
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_SPACE = 3'b010,
		MODE_REPLY = 3'b100
	} mode_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_RING_LENGTH   = 3'd0;
	localparam logic [2:0] CFG_REPLY_TIMEOUT = 3'd1;
	localparam logic [2:0] CFG_SPACE_WAIT    = 3'd2;
	localparam logic [2:0] CFG_MAX_ATTEMPTS  = 3'd3;
	localparam logic [2:0] CFG_CHANNEL       = 3'd4;

	localparam logic [9:0] TIMER_MAX = 10'h3ff;
	localparam logic [7:0] CMD_TYPE  = 8'h01;

	typedef struct packed {
		logic [6:0] ring_length;
		logic [9:0] reply_timeout_ticks;
		logic [7:0] space_wait_ticks;
		logic [2:0] max_attempts;
		logic [3:0] channel_number;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		ring_length:         7'd8,
		reply_timeout_ticks: 10'd600,
		space_wait_ticks:    8'd20,
		max_attempts:        3'd3,
		channel_number:      4'd2
	};

	typedef struct packed {
		opcode_t    opcode;
		logic [1:0] func;
		logic [7:0] pmic_reg;
		logic [7:0] write_value;
		logic [7:0] write_mask;
		logic [5:0] ring_rear;
		logic [5:0] reply_seq;
		logic [7:0] reply_data;
		logic [7:0] reply_code;
	} item_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] pmic_reg;
		logic [7:0] write_value;
		logic [7:0] write_mask;
	} request_t;

	typedef struct packed {
		event_t      event_res;
		logic [5:0]  ring_slot;
		logic [31:0] command_word0;
		logic [23:0] command_word1;
		logic [7:0]  read_value;
		logic [7:0]  fw_code;
		logic [1:0]  fail_cause;
		logic        link_ready;
	} result_t;

endpackage

// ----- hdl/mrte_cfg.sv -----
// Configuration register file of the mailbox ring transaction engine.
module mrte_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [9:0]      cfg_data,
	output mrte_pkg::cfg_t  cfg
);
	import mrte_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RING_LENGTH:   cfg_q.ring_length         <= cfg_data[6:0];
				CFG_REPLY_TIMEOUT: cfg_q.reply_timeout_ticks <= cfg_data;
				CFG_SPACE_WAIT:    cfg_q.space_wait_ticks    <= cfg_data[7:0];
				CFG_MAX_ATTEMPTS:  cfg_q.max_attempts        <= cfg_data[2:0];
				CFG_CHANNEL:       cfg_q.channel_number      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hdl/mrte_ctrl.sv -----
// Transaction state and combinational step logic of the mailbox ring engine.
module mrte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  mrte_pkg::item_t    item,
	input  mrte_pkg::cfg_t     cfg,
	output logic               res_valid,
	output mrte_pkg::result_t  res
);
	import mrte_pkg::*;

	mode_t      mode_q, mode_d;
	logic [5:0] seq_q, seq_d;
	logic [5:0] front_q, front_d;
	logic [5:0] rear_q, rear_d;
	logic [9:0] timer_q, timer_d;
	logic [2:0] attempt_q, attempt_d;
	request_t   pend_q, pend_d;
	logic       ready_q, ready_d;

	logic [6:0] eff_len;
	logic [6:0] front_inc;
	logic [5:0] front_nxt;
	logic [5:0] seq_inc;
	logic [9:0] timer_inc;
	logic [2:0] att_lim;
	request_t   new_req;
	request_t   post_req;
	logic [5:0] post_seq;
	logic       do_post;
	logic       fail;
	logic [1:0] fail_cause;

	// ring length clamped to 2..RING_CAP
	always_comb begin
		eff_len = cfg.ring_length;
		if (eff_len < RING_MIN)
			eff_len = RING_MIN;
		if (eff_len > RING_CAP)
			eff_len = RING_CAP;
	end

	assign front_inc = {1'b0, front_q} + 7'd1;
	assign front_nxt = (front_inc >= eff_len) ? 6'd0 : front_inc[5:0];
	assign seq_inc   = (seq_q == 6'd63) ? 6'd1 : seq_q + 6'd1;
	assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + 10'd1;
	assign att_lim   = (cfg.max_attempts == 3'd0) ? 3'd1 : cfg.max_attempts;

	assign new_req.func        = item.func;
	assign new_req.pmic_reg    = item.pmic_reg;
	assign new_req.write_value = item.write_value;
	assign new_req.write_mask  = item.write_mask;

	always_comb begin
		mode_d    = mode_q;
		seq_d     = seq_q;
		front_d   = front_q;
		rear_d    = rear_q;
		timer_d   = timer_q;
		attempt_d = attempt_q;
		pend_d    = pend_q;
		ready_d   = ready_q;
		do_post   = 1'b0;
		post_seq  = seq_q;
		post_req  = pend_q;
		fail      = 1'b0;
		fail_cause = CAUSE_NONE;
		res_valid = 1'b0;
		res       = '0;

		case (item.opcode)
			OP_REQUEST: begin
				if (mode_q != MODE_IDLE || item.func > REQ_UPDATE) begin
					res_valid     = 1'b1;
					res.event_res = EV_REJECTED;
				end else begin
					pend_d    = new_req;
					attempt_d = 3'd1;
					seq_d     = seq_inc;
					timer_d   = '0;
					mode_d    = MODE_SPACE;
					post_seq  = seq_inc;
					post_req  = new_req;
					do_post   = (front_nxt != rear_q);
				end
			end
			OP_REAR: begin
				rear_d = item.ring_rear;
				if (mode_q == MODE_SPACE)
					do_post = (front_nxt != item.ring_rear);
			end
			OP_REPLY: begin
				if (mode_q == MODE_REPLY && item.reply_seq == seq_q) begin
					mode_d         = MODE_IDLE;
					timer_d        = '0;
					ready_d        = 1'b1;
					res_valid      = 1'b1;
					res.event_res  = EV_DONE;
					res.read_value = (pend_q.func == REQ_READ) ? item.reply_data : 8'd0;
					res.fw_code    = item.reply_code;
				end
			end
			OP_TICK: begin
				if (mode_q == MODE_SPACE) begin
					timer_d    = timer_inc;
					fail       = (timer_inc > {2'b00, cfg.space_wait_ticks});
					fail_cause = CAUSE_FULL;
				end else if (mode_q == MODE_REPLY) begin
					timer_d    = timer_inc;
					fail       = (timer_inc >= cfg.reply_timeout_ticks);
					fail_cause = CAUSE_NO_REPLY;
				end
				if (fail) begin
					timer_d = '0;
					if (attempt_q < att_lim) begin
						// retry: fresh sequence number, try to post again
						attempt_d = attempt_q + 3'd1;
						seq_d     = seq_inc;
						mode_d    = MODE_SPACE;
						post_seq  = seq_inc;
						do_post   = (front_nxt != rear_q);
					end else begin
						mode_d         = MODE_IDLE;
						res_valid      = 1'b1;
						res.event_res  = EV_FAILED;
						res.fail_cause = fail_cause;
					end
				end
			end
			default: begin
			end
		endcase

		if (do_post) begin
			front_d           = front_nxt;
			mode_d            = MODE_REPLY;
			timer_d           = '0;
			res_valid         = 1'b1;
			res.event_res     = EV_POSTED;
			res.ring_slot     = front_q;
			res.command_word0 = {10'd0, post_seq, CMD_TYPE, post_req.pmic_reg};
			res.command_word1 = {post_req.write_mask, post_req.write_value,
				6'd0, post_req.func};
		end

		res.link_ready = ready_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			seq_q     <= 6'd1;
			front_q   <= '0;
			rear_q    <= '0;
			timer_q   <= '0;
			attempt_q <= '0;
			pend_q    <= '0;
			ready_q   <= 1'b0;
		end else if (step_en) begin
			mode_q    <= mode_d;
			seq_q     <= seq_d;
			front_q   <= front_d;
			rear_q    <= rear_d;
			timer_q   <= timer_d;
			attempt_q <= attempt_d;
			pend_q    <= pend_d;
			ready_q   <= ready_d;
		end
	end

	// sequence numbers cycle 1..63, zero never appears
	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != 6'd0)
		else $error("sequence number is zero");

	// an active transaction has used at least one attempt
	a_attempt_active: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_IDLE |-> attempt_q != 3'd0)
		else $error("active transaction with no attempt counted");

	// link ready is sticky
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("link ready dropped");

	// a reply wait only starts through a post
	a_reply_via_post: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode_q != MODE_REPLY && mode_d == MODE_REPLY |-> do_post)
		else $error("reply wait entered without posting");

endmodule

// ----- hdl/mailbox_ring_transaction_engine.sv -----
// Top level of the mailbox ring transaction engine: channels and registers.
//
// Requester side of a ring-queue mailbox. Each input word is a request, a
// ring rear update, a reply entry or a millisecond tick (opcode). A request
// takes the next sequence number and posts two command words at the ring's
// front slot, or waits for room; replies are matched on their sequence
// field, and ticks time out a full ring or a missing reply, with retries.
//
// Channels: input words on in_valid/in_stall, result words on
// out_valid/out_stall; a word moves on an edge with valid high and stall
// low. Each input word gives zero or one result word. Config writes go in
// on cfg_valid/cfg_ready (always ready); the user must make them only while
// idle, and the block itself does not enforce it.
// Timing: an accepted word is held in the input register and worked on by
// the combinational step logic; its result lands in the output register.
// One word per cycle is sustained while the receiver does not stall: the
// step logic is the only path and holds no loop.
// If the receiver stalls with a result waiting, the input register holds and
// in_stall rises; words that give no result are held the same way.
// Reset clears all state: sequence number 1, ring indexes 0, registers to
// their defaults, both channels empty.
module mailbox_ring_transaction_engine (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [1:0]  func,
	input  logic [7:0]  pmic_reg,
	input  logic [7:0]  write_value,
	input  logic [7:0]  write_mask,
	input  logic [5:0]  ring_rear,
	input  logic [5:0]  reply_seq,
	input  logic [7:0]  reply_data,
	input  logic [7:0]  reply_code,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [5:0]  ring_slot,
	output logic [31:0] command_word0,
	output logic [23:0] command_word1,
	output logic [7:0]  read_value,
	output logic [7:0]  fw_code,
	output logic [1:0]  fail_cause,
	output logic        link_ready,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import mrte_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    step_valid;
	result_t step_res;
	result_t res_q;
	logic    out_valid_q;

	assign item_in.opcode      = opcode_t'(opcode);
	assign item_in.func        = func;
	assign item_in.pmic_reg    = pmic_reg;
	assign item_in.write_value = write_value;
	assign item_in.write_mask  = write_mask;
	assign item_in.ring_rear   = ring_rear;
	assign item_in.reply_seq   = reply_seq;
	assign item_in.reply_data  = reply_data;
	assign item_in.reply_code  = reply_code;

	// The held word steps when the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	mrte_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mrte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (step_valid),
		.res       (step_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= item_in;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid)
			res_q <= step_res;
	end

	assign out_valid     = out_valid_q;
	assign event_res     = res_q.event_res;
	assign ring_slot     = res_q.ring_slot;
	assign command_word0 = res_q.command_word0;
	assign command_word1 = res_q.command_word1;
	assign read_value    = res_q.read_value;
	assign fw_code       = res_q.fw_code;
	assign fail_cause    = res_q.fail_cause;
	assign link_ready    = res_q.link_ready;

endmodule

// ----- dv/tb_mailbox_ring_transaction_engine.sv -----
// Self-checking testbench for the mailbox ring transaction engine.
module tb_mailbox_ring_transaction_engine;
	import mrte_pkg::*;

	// How a queued word is tied to the engine state at the moment it is presented:
	// reply carrying the live sequence number, rear update that frees the ring,
	// rear update that fills it.
	typedef enum logic [1:0] {
		TIE_NONE = 2'd0,
		TIE_SEQ  = 2'd1,
		TIE_ROOM = 2'd2,
		TIE_FULL = 2'd3
	} tie_t;

	typedef struct packed {
		item_t word;
		tie_t  tie;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [1:0]  func;
	logic [7:0]  pmic_reg;
	logic [7:0]  write_value;
	logic [7:0]  write_mask;
	logic [5:0]  ring_rear;
	logic [5:0]  reply_seq;
	logic [7:0]  reply_data;
	logic [7:0]  reply_code;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_res;
	logic [5:0]  ring_slot;
	logic [31:0] command_word0;
	logic [23:0] command_word1;
	logic [7:0]  read_value;
	logic [7:0]  fw_code;
	logic [1:0]  fail_cause;
	logic        link_ready;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_RING_LENGTH;
	logic [9:0]  cfg_data = '0;

	// Word currently on the input port; fields fan out to the ports below.
	item_t cur_word = '0;
	assign opcode      = cur_word.opcode;
	assign func        = cur_word.func;
	assign pmic_reg    = cur_word.pmic_reg;
	assign write_value = cur_word.write_value;
	assign write_mask  = cur_word.write_mask;
	assign ring_rear   = cur_word.ring_rear;
	assign reply_seq   = cur_word.reply_seq;
	assign reply_data  = cur_word.reply_data;
	assign reply_code  = cur_word.reply_code;

	mailbox_ring_transaction_engine uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("tb_mailbox_ring_transaction_engine NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Engine predictor: own copy of registers and transaction state,
	// updated once per accepted input word.
	// ------------------------------------------------------------------
	cfg_t       shadow_cfg = CFG_RESET;
	mode_t      eng_mode = MODE_IDLE;
	logic [5:0] eng_seq = 6'd1;
	logic [5:0] eng_front = '0;
	logic [5:0] eng_rear = '0;
	logic [9:0] eng_timer = '0;
	logic [2:0] eng_tries = '0;
	request_t   eng_req = '0;
	logic       eng_linked = 1'b0;

	stim_t   pending[$];       // words waiting for the driver
	result_t awaited[$];       // predicted result words, oldest first
	int      words_queued = 0;
	int      words_sent = 0;
	int      faults = 0;
	bit      calm = 1'b0;      // no idling on either side once set

	function automatic result_t quiet_result();
		result_t r;
		r = '0;
		r.event_res = EV_POSTED;
		r.link_ready = eng_linked;
		return r;
	endfunction

	// Slot after the front, wrapping at the clamped ring length.
	function automatic logic [5:0] following_slot();
		int span;
		int nf;
		span = shadow_cfg.ring_length;
		if (span < RING_MIN) span = RING_MIN;
		if (span > RING_CAP) span = RING_CAP;
		nf = eng_front + 1;
		return (nf >= span) ? 6'd0 : 6'(nf);
	endfunction

	// Post the held request at the front slot unless the ring is full.
	function automatic bit post_if_room(output result_t r);
		logic [5:0] nf;
		r = quiet_result();
		nf = following_slot();
		if (nf == eng_rear)
			return 1'b0;
		r.event_res = EV_POSTED;
		r.ring_slot = eng_front;
		r.command_word0 = {10'd0, eng_seq, CMD_TYPE, eng_req.pmic_reg};
		r.command_word1 = {eng_req.write_mask, eng_req.write_value, 6'd0, eng_req.func};
		eng_front = nf;
		eng_mode = MODE_REPLY;
		eng_timer = '0;
		return 1'b1;
	endfunction

	function automatic bit begin_attempt(output result_t r);
		eng_tries = eng_tries + 3'd1;
		eng_seq = 6'((int'(eng_seq) % 63) + 1);
		eng_timer = '0;
		eng_mode = MODE_SPACE;
		return post_if_room(r);
	endfunction

	// Retry while attempts remain, else report the failure cause.
	function automatic bit attempt_lost(input logic [1:0] cause, output result_t r);
		logic [2:0] lim;
		lim = (shadow_cfg.max_attempts == 3'd0) ? 3'd1 : shadow_cfg.max_attempts;
		if (eng_tries < lim)
			return begin_attempt(r);
		eng_mode = MODE_IDLE;
		eng_timer = '0;
		r = quiet_result();
		r.event_res = EV_FAILED;
		r.fail_cause = cause;
		return 1'b1;
	endfunction

	function automatic bit engine_step(input item_t w, output result_t r);
		r = quiet_result();
		case (w.opcode)
			OP_REQUEST: begin
				if (eng_mode != MODE_IDLE || w.func > REQ_UPDATE) begin
					r.event_res = EV_REJECTED;
					return 1'b1;
				end
				eng_req.func = w.func;
				eng_req.pmic_reg = w.pmic_reg;
				eng_req.write_value = w.write_value;
				eng_req.write_mask = w.write_mask;
				eng_tries = '0;
				return begin_attempt(r);
			end
			OP_REAR: begin
				eng_rear = w.ring_rear;
				if (eng_mode == MODE_SPACE)
					return post_if_room(r);
				return 1'b0;
			end
			OP_REPLY: begin
				if (eng_mode != MODE_REPLY || w.reply_seq != eng_seq)
					return 1'b0;
				eng_mode = MODE_IDLE;
				eng_timer = '0;
				eng_linked = 1'b1;
				r = quiet_result();
				r.event_res = EV_DONE;
				r.read_value = (eng_req.func == REQ_READ) ? w.reply_data : 8'd0;
				r.fw_code = w.reply_code;
				return 1'b1;
			end
			default: begin
				if (eng_mode == MODE_SPACE) begin
					if (eng_timer < TIMER_MAX) eng_timer = eng_timer + 10'd1;
					if (eng_timer > shadow_cfg.space_wait_ticks)
						return attempt_lost(CAUSE_FULL, r);
				end else if (eng_mode == MODE_REPLY) begin
					if (eng_timer < TIMER_MAX) eng_timer = eng_timer + 10'd1;
					if (eng_timer >= shadow_cfg.reply_timeout_ticks)
						return attempt_lost(CAUSE_NO_REPLY, r);
				end
				return 1'b0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued words, predicts on every accepted word.
	// Valid is decided before looking at stall; a stalled word is held.
	// ------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk) begin
		result_t res;
		stim_t   s;
		item_t   w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (engine_step(cur_word, res))
					awaited.push_back(res);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				// occasional idle burst right after a word goes in
				if (in_valid && !calm && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 17);
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					s = pending.pop_front();
					w = s.word;
					// state is current here: the previous word was just predicted
					case (s.tie)
						TIE_SEQ:  w.reply_seq = eng_seq;
						TIE_ROOM: w.ring_rear = eng_front;
						TIE_FULL: w.ring_rear = following_slot();
						default: ;
					endcase
					cur_word <= w;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result word, drives stall bursts.
	// ------------------------------------------------------------------
	int stall_left = 0;

	function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, tag, want, got);
			faults++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$display("%0t: result word with none awaited, expected none, got event %0d",
						$time, event_res);
					faults++;
				end else begin
					want = awaited.pop_front();
					check_field("event_res", want.event_res, event_res);
					check_field("ring_slot", want.ring_slot, ring_slot);
					check_field("command_word0", want.command_word0, command_word0);
					check_field("command_word1", want.command_word1, command_word1);
					check_field("read_value", want.read_value, read_value);
					check_field("fw_code", want.fw_code, fw_code);
					check_field("fail_cause", want.fail_cause, fail_cause);
					check_field("link_ready", want.link_ready, link_ready);
				end
			end
			if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 17);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic item_t random_word(opcode_t op);
		logic [63:0] bits;
		item_t w;
		bits = {$urandom, $urandom};
		w = bits[$bits(item_t)-1:0];
		w.opcode = op;
		return w;
	endfunction

	task automatic push(item_t w, tie_t t);
		stim_t s;
		s.word = w;
		s.tie = t;
		pending.push_back(s);
		words_queued++;
	endtask

	task automatic ask(logic [1:0] f, logic [7:0] rg, logic [7:0] val, logic [7:0] msk);
		item_t w;
		w = random_word(OP_REQUEST);
		w.func = f;
		w.pmic_reg = rg;
		w.write_value = val;
		w.write_mask = msk;
		push(w, TIE_NONE);
	endtask

	task automatic answer(logic [7:0] data, logic [7:0] code);
		item_t w;
		w = random_word(OP_REPLY);
		w.reply_data = data;
		w.reply_code = code;
		push(w, TIE_SEQ);
	endtask

	task automatic tick_run(int n);
		repeat (n) push(random_word(OP_TICK), TIE_NONE);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [9:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_RING_LENGTH:   shadow_cfg.ring_length = val[6:0];
			CFG_REPLY_TIMEOUT: shadow_cfg.reply_timeout_ticks = val[9:0];
			CFG_SPACE_WAIT:    shadow_cfg.space_wait_ticks = val[7:0];
			CFG_MAX_ATTEMPTS:  shadow_cfg.max_attempts = val[2:0];
			CFG_CHANNEL:       shadow_cfg.channel_number = val[3:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(int len, int reply, int space, int tries, int chan);
		write_reg(CFG_RING_LENGTH, 10'(len));
		write_reg(CFG_REPLY_TIMEOUT, 10'(reply));
		write_reg(CFG_SPACE_WAIT, 10'(space));
		write_reg(CFG_MAX_ATTEMPTS, 10'(tries));
		write_reg(CFG_CHANNEL, 10'(chan));
	endtask

	// Sender holds off until every word is in and every result is out, then
	// closes any open transaction so registers change only on an idle engine.
	task automatic settle();
		forever begin
			do @(posedge clk); while (words_sent != words_queued || awaited.size() != 0);
			// words with no result may still be in the two-stage pipe
			repeat (4) @(posedge clk);
			if (eng_mode == MODE_SPACE)
				push(random_word(OP_REAR), TIE_ROOM);
			else if (eng_mode == MODE_REPLY)
				answer(8'($urandom), 8'($urandom));
			else
				break;
		end
	endtask

	// One transaction with random content, some noise and either a reply or
	// enough ticks to run through timeouts and retries.
	task automatic add_transaction();
		int    lim;
		int    span;
		item_t w;
		lim = (shadow_cfg.max_attempts == 3'd0) ? 1 : shadow_cfg.max_attempts;
		span = (shadow_cfg.reply_timeout_ticks > shadow_cfg.space_wait_ticks) ?
			shadow_cfg.reply_timeout_ticks + 1 : shadow_cfg.space_wait_ticks + 2;
		if ($urandom_range(0, 3) == 0)
			push(random_word(OP_REAR), TIE_FULL);
		w = random_word(OP_REQUEST);
		if ($urandom_range(0, 9) != 0)
			w.func = 2'($urandom_range(0, 2));
		push(w, TIE_NONE);
		repeat ($urandom_range(0, 2))
			push(random_word(opcode_t'($urandom_range(0, 3))), TIE_NONE);
		if ($urandom_range(0, 1) == 0)
			push(random_word(OP_REAR), TIE_ROOM);
		if ($urandom_range(0, 9) < 3) begin
			tick_run($urandom_range(1, span * lim));
		end else begin
			tick_run($urandom_range(0, 2));
			answer(8'($urandom), 8'($urandom));
		end
	endtask

	task automatic random_phase(int n);
		int first;
		first = words_queued;
		while (words_queued - first < n)
			add_transaction();
		settle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		item_t w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values.
		tick_run(1);                                   // stray tick while idle
		push(random_word(OP_REPLY), TIE_NONE);         // stray reply while idle
		ask(REQ_READ, 8'h00, 8'h00, 8'h00);
		ask(REQ_WRITE, 8'h12, 8'h34, 8'h56);           // busy: rejected
		w = random_word(OP_REPLY);
		w.reply_seq = 6'd0;                            // never a live sequence number
		push(w, TIE_NONE);
		answer(8'hff, 8'h00);
		ask(2'd3, 8'h01, 8'h02, 8'h03);                // bad func: rejected
		ask(REQ_UPDATE, 8'hff, 8'hff, 8'hff);
		answer(8'h5a, 8'hff);                          // read data masked off
		push(random_word(OP_REAR), TIE_FULL);          // ring full at request time
		ask(REQ_WRITE, 8'h80, 8'h01, 8'h00);
		push(random_word(OP_REAR), TIE_ROOM);          // room: post right away
		answer(8'h00, 8'h3c);
		settle();

		// Short timeouts, length below the clamp, one retry.
		set_regs(1, 3, 2, 2, 15);
		push(random_word(OP_REAR), TIE_ROOM);
		ask(REQ_WRITE, 8'h55, 8'haa, 8'h0f);
		tick_run(3);                                   // no reply, retry posts again
		tick_run(3);                                   // second reply timeout ends it
		w = random_word(OP_REAR);
		w.ring_rear = 6'd63;                           // rear past the ring: never full
		push(w, TIE_NONE);
		ask(REQ_READ, 8'hc3, 8'h3c, 8'hf0);
		tick_run(6);                                   // reply timeout twice
		settle();

		// Largest ring and waits, one attempt; reply and room come well inside the waits.
		set_regs(64, 1023, 255, 1, 0);
		push(random_word(OP_REAR), TIE_ROOM);
		ask(REQ_READ, 8'h7e, 8'h81, 8'h18);
		tick_run(40);
		answer(8'h99, 8'h00);
		push(random_word(OP_REAR), TIE_FULL);
		ask(REQ_UPDATE, 8'h81, 8'h7e, 8'he7);
		tick_run(40);
		push(random_word(OP_REAR), TIE_ROOM);
		answer(8'h42, 8'h01);
		settle();

		// Random transactions over several register settings.
		set_regs(2, 1, 1, 7, 0);
		random_phase(64);
		set_regs(127, $urandom_range(2, 8), $urandom_range(1, 6), 0, 15);
		random_phase(64);
		set_regs(0, $urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 7),
			$urandom_range(0, 15));
		random_phase(64);
		set_regs($urandom_range(2, 64), $urandom_range(1, 8), $urandom_range(1, 6),
			$urandom_range(0, 7), $urandom_range(0, 15));
		random_phase(64);
		calm = 1'b1;                                   // full rate to the end
		set_regs(64, 4, 3, 3, 2);
		random_phase(64);

		if (faults == 0)
			$display("tb_mailbox_ring_transaction_engine OK");
		else
			$display("tb_mailbox_ring_transaction_engine NOT OK");
		$finish;
	end

endmodule
